// File: src/srsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow return stack checker package
// Shared widths, request codes and the word types passed between the cells.
// ----------------------------------------------------------------------------
package srsc_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned DEPTH_W = 7;

  localparam logic REQ_CALL   = 1'b0;
  localparam logic REQ_RETURN = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] ret_addr;
    logic [ADDR_W-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

// File: src/srsc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow return stack cell
// One stack entry. On a push it takes the entry of the cell above it, on a
// pop the entry of the cell below it, and otherwise it holds.
// ----------------------------------------------------------------------------
module srsc_cell (
  input  logic            clk_i,
  input  srsc_pkg::shift_t ctl_i,
  input  srsc_pkg::entry_t above_i,
  input  srsc_pkg::entry_t below_i,
  output srsc_pkg::entry_t entry_o
);
  import srsc_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.push) begin
      entry_d = above_i;
    end else if (ctl_i.pop) begin
      entry_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: src/shadow_return_stack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow return stack checker
// Records return address and frame pointer on each call and checks both
// against the top entry on each return, popping it.
//
//   Port group        Direction  Handshake
//   request word      in         start / busy
//   result word       out        done_o strobe, one cycle, cannot be stalled
//
// One word is taken per cycle; busy is never raised. The result appears on
// the cycle after the request is taken, out of a register behind the top cell.
// The stack is a row of STACK_DEPTH cells that all shift together, so a push
// or pop moves every cell at once whatever the depth. Reset empties the stack at once;
// cell contents are left as they are and only read once written.
// ----------------------------------------------------------------------------
module shadow_return_stack_checker #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         req_type_i,
  input  logic [srsc_pkg::ADDR_W-1:0]  return_address_i,
  input  logic [srsc_pkg::ADDR_W-1:0]  frame_pointer_i,
  output logic                         done_o,
  output logic                         ret_mismatch_o,
  output logic                         fp_mismatch_o,
  output logic [srsc_pkg::ADDR_W-1:0]  expected_return_o,
  output logic [srsc_pkg::ADDR_W-1:0]  expected_frame_o,
  output logic                         underflow_o,
  output logic                         overflow_o,
  output logic [srsc_pkg::DEPTH_W-1:0] depth_now_o
);
  import srsc_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);

  logic              accept;
  logic              is_ret;
  logic              empty;
  logic              full;
  shift_t            ctl;
  entry_t            new_entry;
  entry_t            cell_q [STACK_DEPTH];
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_d;
  logic [CNT_W+DEPTH_W-1:0] count_ext;

  logic               done_q;
  logic               ret_mis_q, ret_mis_d;
  logic               fp_mis_q, fp_mis_d;
  logic [ADDR_W-1:0]  exp_ret_q, exp_ret_d;
  logic [ADDR_W-1:0]  exp_frame_q, exp_frame_d;
  logic               under_q, under_d;
  logic               over_q, over_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign is_ret = (req_type_i == REQ_RETURN);
  assign empty  = (count_q == '0);
  assign full   = (count_q == FULL);

  assign ctl.push = accept && !is_ret;
  assign ctl.pop  = accept && is_ret && !empty;

  assign new_entry.ret_addr = return_address_i;
  assign new_entry.frame    = frame_pointer_i;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t above;
    entry_t below;
    if (i == 0) begin : g_top
      assign above = new_entry;
    end else begin : g_mid_above
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below = '0;
    end else begin : g_mid_below
      assign below = cell_q[i+1];
    end
    srsc_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .above_i (above),
      .below_i (below),
      .entry_o (cell_q[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    ret_mis_d   = 1'b0;
    fp_mis_d    = 1'b0;
    exp_ret_d   = '0;
    exp_frame_d = '0;
    under_d     = 1'b0;
    over_d      = 1'b0;
    if (ctl.push) begin
      if (full) begin
        over_d = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else if (accept) begin
      if (empty) begin
        under_d = 1'b1;
      end else begin
        count_d     = count_q - 1'b1;
        exp_ret_d   = cell_q[0].ret_addr;
        exp_frame_d = cell_q[0].frame;
        ret_mis_d   = (cell_q[0].ret_addr != return_address_i);
        fp_mis_d    = (cell_q[0].frame != frame_pointer_i);
      end
    end
  end

  assign count_ext = {{DEPTH_W{1'b0}}, count_d};
  assign depth_d   = count_ext[DEPTH_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ret_mis_q   <= ret_mis_d;
      fp_mis_q    <= fp_mis_d;
      exp_ret_q   <= exp_ret_d;
      exp_frame_q <= exp_frame_d;
      under_q     <= under_d;
      over_q      <= over_d;
      depth_q     <= depth_d;
    end
  end

  assign done_o            = done_q;
  assign ret_mismatch_o    = ret_mis_q;
  assign fp_mismatch_o     = fp_mis_q;
  assign expected_return_o = exp_ret_q;
  assign expected_frame_o  = exp_frame_q;
  assign underflow_o       = under_q;
  assign overflow_o        = over_q;
  assign depth_now_o       = depth_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL)
    else $error("stack count beyond depth");

  a_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_ret && empty |=> done_o && underflow_o && count_q == '0)
    else $error("return on empty stack not flagged or state changed");

  a_overflow_keeps_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_ret && full |=> overflow_o && count_q == FULL)
    else $error("call on full stack mishandled");

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(underflow_o && overflow_o))
    else $error("underflow and overflow flagged together");

  a_push_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.push |=> cell_q[0] == $past(new_entry))
    else $error("pushed word not at top of stack");

endmodule

// File: tb/tb_shadow_return_stack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow return stack checker testbench
// Sends call and return words through the start / busy handshake and checks
// every result word against a local shadow stack or its typed table row. A
// short table covers the empty-stack return, the address extremes and both
// kinds of mismatch; random bursts then fill the stack past overflow, drain
// it into underflow and mostly return the recorded pair, at times corrupted.
// ----------------------------------------------------------------------------
module tb_shadow_return_stack_checker;
  import srsc_pkg::*;

  localparam int unsigned STACK_DEPTH  = 64;
  localparam int unsigned RANDOM_WORDS = 1330;
  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

  typedef struct packed {
    logic               ret_mis;
    logic               fp_mis;
    logic [ADDR_W-1:0]  exp_ret;
    logic [ADDR_W-1:0]  exp_frame;
    logic               under;
    logic               over;
    logic [DEPTH_W-1:0] depth;
  } verdict_t;

  typedef struct packed {
    logic              req;
    logic [ADDR_W-1:0] ret_addr;
    logic [ADDR_W-1:0] frame;
    logic              typed;
    verdict_t          want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               req_type;
  logic [ADDR_W-1:0]  ret_addr_d;
  logic [ADDR_W-1:0]  frame_d;
  logic               done;
  logic               ret_mis;
  logic               fp_mis;
  logic [ADDR_W-1:0]  exp_ret;
  logic [ADDR_W-1:0]  exp_frame;
  logic               under;
  logic               over;
  logic [DEPTH_W-1:0] depth;

  logic [ADDR_W-1:0] shadow_ret [STACK_DEPTH];
  logic [ADDR_W-1:0] shadow_frame [STACK_DEPTH];
  int unsigned       held_count;
  int unsigned       top_slot;

  verdict_t  pending_verdicts[$];
  plan_row_t plan[$];

  int unsigned errors;
  int unsigned calls_sent;
  int unsigned returns_sent;
  int unsigned overflows_seen;
  int unsigned underflows_seen;
  int unsigned bad_returns;
  int unsigned deepest;

  shadow_return_stack_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type),
    .return_address_i  (ret_addr_d),
    .frame_pointer_i   (frame_d),
    .done_o            (done),
    .ret_mismatch_o    (ret_mis),
    .fp_mismatch_o     (fp_mis),
    .expected_return_o (exp_ret),
    .expected_frame_o  (exp_frame),
    .underflow_o       (under),
    .overflow_o        (over),
    .depth_now_o       (depth)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic verdict_t mk_verdict(logic rm, logic fm, logic [ADDR_W-1:0] er,
                                          logic [ADDR_W-1:0] ef, logic un, logic ov,
                                          logic [DEPTH_W-1:0] d);
    verdict_t v;
    v.ret_mis   = rm;
    v.fp_mis    = fm;
    v.exp_ret   = er;
    v.exp_frame = ef;
    v.under     = un;
    v.over      = ov;
    v.depth     = d;
    return v;
  endfunction

  task automatic add_row(logic req, logic [ADDR_W-1:0] ra, logic [ADDR_W-1:0] fp,
                         logic typed, verdict_t want);
    plan_row_t r;
    r.req      = req;
    r.ret_addr = ra;
    r.frame    = fp;
    r.typed    = typed;
    r.want     = want;
    plan.push_back(r);
  endtask

  // Advances the local shadow stack by one word and returns the verdict it implies.
  task automatic shadow_step(input logic req, input logic [ADDR_W-1:0] ra,
                             input logic [ADDR_W-1:0] fp, output verdict_t v);
    int unsigned slot;
    v = '0;
    if (req == REQ_CALL) begin
      calls_sent++;
      shadow_ret[top_slot]   = ra;
      shadow_frame[top_slot] = fp;
      top_slot = (top_slot + 1 >= STACK_DEPTH) ? 0 : top_slot + 1;
      if (held_count >= STACK_DEPTH) begin
        v.over = 1'b1;
        overflows_seen++;
      end else begin
        held_count++;
      end
    end else begin
      returns_sent++;
      if (held_count == 0) begin
        v.under = 1'b1;
        underflows_seen++;
      end else begin
        slot        = (top_slot == 0) ? STACK_DEPTH - 1 : top_slot - 1;
        v.exp_ret   = shadow_ret[slot];
        v.exp_frame = shadow_frame[slot];
        v.ret_mis   = (v.exp_ret != ra);
        v.fp_mis    = (v.exp_frame != fp);
        if (v.ret_mis || v.fp_mis) bad_returns++;
        top_slot = slot;
        held_count--;
      end
    end
    v.depth = held_count[DEPTH_W-1:0];
    if (held_count > deepest) deepest = held_count;
  endtask

  task automatic send_word(logic req, logic [ADDR_W-1:0] ra, logic [ADDR_W-1:0] fp,
                           logic typed, verdict_t want, int unsigned gap);
    verdict_t predicted;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    req_type   <= req;
    ret_addr_d <= ra;
    frame_d    <= fp;
    do @(posedge clk); while (busy);
    shadow_step(req, ra, fp, predicted);
    pending_verdicts.push_back(typed ? want : predicted);
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return '0;
      1: return ALL_ONES;
      2: return {{(ADDR_W-1){1'b0}}, 1'b1} << $urandom_range(0, ADDR_W-1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(posedge clk) begin
    verdict_t w;
    if (rst_n && done) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result word with nothing outstanding, depth %0d", $time, depth);
        errors++;
      end else begin
        w = pending_verdicts.pop_front();
        if (ret_mis !== w.ret_mis) begin
          $display("%0t: ret_mismatch expected %0b actual %0b", $time, w.ret_mis, ret_mis);
          errors++;
        end
        if (fp_mis !== w.fp_mis) begin
          $display("%0t: fp_mismatch expected %0b actual %0b", $time, w.fp_mis, fp_mis);
          errors++;
        end
        if (exp_ret !== w.exp_ret) begin
          $display("%0t: expected_return expected %h actual %h", $time, w.exp_ret, exp_ret);
          errors++;
        end
        if (exp_frame !== w.exp_frame) begin
          $display("%0t: expected_frame expected %h actual %h", $time, w.exp_frame,
                   exp_frame);
          errors++;
        end
        if (under !== w.under) begin
          $display("%0t: underflow expected %0b actual %0b", $time, w.under, under);
          errors++;
        end
        if (over !== w.over) begin
          $display("%0t: overflow expected %0b actual %0b", $time, w.over, over);
          errors++;
        end
        if (depth !== w.depth) begin
          $display("%0t: depth_now expected %0d actual %0d", $time, w.depth, depth);
          errors++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("shadow_return_stack_checker: mismatch");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned call_pct;
    int unsigned burst_len;
    int unsigned slot;
    bit          quiet;
    logic              req;
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] fp;

    errors          = 0;
    calls_sent      = 0;
    returns_sent    = 0;
    overflows_seen  = 0;
    underflows_seen = 0;
    bad_returns     = 0;
    deepest         = 0;
    held_count      = 0;
    top_slot        = 0;
    rst_n      <= 1'b0;
    start      <= 1'b0;
    req_type   <= REQ_CALL;
    ret_addr_d <= '0;
    frame_d    <= '0;

    add_row(REQ_RETURN, '0, '0, 1'b1, mk_verdict(0, 0, '0, '0, 1, 0, 0));
    add_row(REQ_CALL, '0, '0, 1'b1, mk_verdict(0, 0, '0, '0, 0, 0, 1));
    add_row(REQ_RETURN, '0, '0, 1'b1, mk_verdict(0, 0, '0, '0, 0, 0, 0));
    add_row(REQ_RETURN, ALL_ONES, ALL_ONES, 1'b1, mk_verdict(0, 0, '0, '0, 1, 0, 0));
    add_row(REQ_CALL, ALL_ONES, ALL_ONES, 1'b1, mk_verdict(0, 0, '0, '0, 0, 0, 1));
    add_row(REQ_CALL, '0, ALL_ONES, 1'b1, mk_verdict(0, 0, '0, '0, 0, 0, 2));
    add_row(REQ_RETURN, ALL_ONES, ALL_ONES, 1'b1,
            mk_verdict(1, 0, '0, ALL_ONES, 0, 0, 1));
    add_row(REQ_RETURN, '0, '0, 1'b1, mk_verdict(1, 1, ALL_ONES, ALL_ONES, 0, 0, 0));
    add_row(REQ_CALL, 64'h8000_0000_0000_0000, 64'h1, 1'b1,
            mk_verdict(0, 0, '0, '0, 0, 0, 1));
    add_row(REQ_RETURN, 64'h8000_0000_0000_0000, 64'h0, 1'b1,
            mk_verdict(0, 1, 64'h8000_0000_0000_0000, 64'h1, 0, 0, 0));
    add_row(REQ_CALL, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0, '0);
    add_row(REQ_CALL, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, '0);
    add_row(REQ_CALL, 64'h0000_7FFF_FFFF_F000, 64'h0000_7FFF_FFFF_E000, 1'b0, '0);
    add_row(REQ_RETURN, 64'h0000_7FFF_FFFF_F000, 64'h0000_7FFF_FFFF_E008, 1'b0, '0);
    add_row(REQ_RETURN, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0);
    add_row(REQ_RETURN, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0, '0);
    add_row(REQ_RETURN, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      send_word(plan[i].req, plan[i].ret_addr, plan[i].frame, plan[i].typed,
                plan[i].want, $urandom_range(0, 13));
    end

    // Burst zero fills the stack well past overflow and burst one drains it into
    // underflow; later bursts wander between the two with a random call bias.
    sent  = 0;
    burst = 0;
    while (sent < RANDOM_WORDS) begin
      call_pct  = (burst == 0) ? 100 : (burst == 1) ? 0 : $urandom_range(0, 10) * 10;
      burst_len = (burst < 2) ? 80 : $urandom_range(15, 120);
      quiet     = ($urandom_range(0, 3) == 0);
      for (int unsigned k = 0; k < burst_len && sent < RANDOM_WORDS; k++) begin
        req = ($urandom_range(0, 99) < call_pct) ? REQ_CALL : REQ_RETURN;
        ra  = rand_addr();
        fp  = rand_addr();
        if (req == REQ_RETURN && held_count != 0 && $urandom_range(0, 99) < 80) begin
          slot = (top_slot == 0) ? STACK_DEPTH - 1 : top_slot - 1;
          ra   = shadow_ret[slot];
          fp   = shadow_frame[slot];
          case ($urandom_range(0, 9))
            0: ra = ra ^ ({{(ADDR_W-1){1'b0}}, 1'b1} << $urandom_range(0, ADDR_W-1));
            1: fp = fp ^ ({{(ADDR_W-1){1'b0}}, 1'b1} << $urandom_range(0, ADDR_W-1));
            2: begin
              ra = rand_addr();
              fp = rand_addr();
            end
            default: ;
          endcase
        end
        send_word(req, ra, fp, 1'b0, '0, quiet ? 0 : $urandom_range(0, 13));
        sent++;
      end
      burst++;
    end
    start <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d calls and %0d returns in %0d bursts; deepest stack %0d entries.",
             calls_sent, returns_sent, burst, deepest);
    $display("Saw %0d overflows, %0d underflows and %0d returns with a mismatch.",
             overflows_seen, underflows_seen, bad_returns);
    if (errors == 0) begin
      $display("shadow_return_stack_checker: match");
    end else begin
      $display("shadow_return_stack_checker: mismatch");
    end
    $finish;
  end

endmodule
